// ===== rtl/allocation_bitmap_scan_unit_defines.svh =====
// assertion macros for the bitmap scan unit
`ifndef ALLOCATION_BITMAP_SCAN_UNIT_DEFINES_SVH
`define ALLOCATION_BITMAP_SCAN_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define ABS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ABS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABS_ASSERT(lbl, prop, msg)
`define ABS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== rtl/abs_pkg.sv =====
package abs_pkg;

  localparam int KIND_W        = 3;
  localparam int IDX_W         = 10;
  localparam int NUM_BITS_W    = 11;
  localparam int NUM_BITS_RST  = 1024;
  localparam int MAX_BITS_DEF  = 1024;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET_BIT  = 3'd0,
    KIND_CLR_BIT  = 3'd1,
    KIND_SET_ALL  = 3'd2,
    KIND_CLR_ALL  = 3'd3,
    KIND_FIND_SET = 3'd4,
    KIND_FIND_CLR = 3'd5,
    KIND_READ_BIT = 3'd6
  } kind_t;

endpackage

// ===== rtl/allocation_bitmap_scan_unit.sv =====
// Occupancy bitmap with single-bit set, clear and read, set all, clear all and
// find-lowest-set or find-lowest-clear. The bitmap lives in a single-port word
// memory with a registered read, and one word is visited per cycle, so the
// memory port sets the latency. A request is taken when start is high and busy
// is low; its one result appears on the out_ ports for exactly one cycle with
// out_valid high, and must be captured then since the receiver cannot stall.
// With W = ceil(MAX_BITS / WORD_BITS) words (32 by default): a find reads words
// upward until one holds a match or up to the last; set, clear or read of bit i
// walks to its word, then reads or rewrites it; set all writes all W words in
// turn; clear all, an unknown kind or an out-of-range index answer from idle
// with busy low. Otherwise busy stays high from the cycle after accept until the
// result strobe. The bitmap reads as all zeros right after reset. num_bits is
// written through the cfg_ port while busy and start are both low.
`include "allocation_bitmap_scan_unit_defines.svh"

module allocation_bitmap_scan_unit #(
  parameter int MAX_BITS  = abs_pkg::MAX_BITS_DEF,
  parameter int WORD_BITS = abs_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [abs_pkg::KIND_W-1:0]     in_kind,
  input  logic [abs_pkg::IDX_W-1:0]      in_bit_index,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [abs_pkg::IDX_W-1:0]      out_result_index,
  output logic                          out_bit_value,
  output logic                          out_index_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [abs_pkg::NUM_BITS_W-1:0] cfg_num_bits
);

  import abs_pkg::*;

  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int BASE_W    = $clog2(NUM_WORDS * WORD_BITS);
  localparam int LIM_W     = $clog2(MAX_BITS + 1);
  localparam int MAX_W     = (BASE_W > LIM_W) ? BASE_W : LIM_W;
  localparam int CMP_W     = ((MAX_W > NUM_BITS_W) ? MAX_W : NUM_BITS_W) + 1;
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(NUM_WORDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOCATE,
    ST_MODIFY,
    ST_SCAN,
    ST_FILL
  } state_t;

  state_t                 state_r, state_nxt;
  logic [WA_W-1:0]        word_r, word_nxt;
  logic [BASE_W-1:0]      base_r, base_nxt;
  logic [BASE_W-1:0]      pbase_r, pbase_nxt;
  logic                   pend_r, pend_nxt;
  logic                   plast_r, plast_nxt;
  logic                   issued_r, issued_nxt;
  logic                   want_r, want_nxt;
  logic [KIND_W-1:0]      kind_r, kind_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  logic [NUM_BITS_W-1:0]  num_bits_r, num_bits_nxt;
  logic [NUM_WORDS-1:0]   valid_r, valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       res_idx_r, res_idx_nxt;
  logic                   bit_val_r, bit_val_nxt;
  logic                   err_r, err_nxt;

  logic [WORD_BITS-1:0]   mem [NUM_WORDS];
  logic [WORD_BITS-1:0]   rd_data_r;
  logic                   rd_vld_r;
  logic                   mem_we;
  logic [WORD_BITS-1:0]   mem_wdata;

  logic [CMP_W-1:0]       lim;
  logic [WORD_BITS-1:0]   cur_word;
  logic [WORD_BITS-1:0]   scan_vec;
  logic [WORD_BITS-1:0]   bit_mask;
  logic [CMP_W-1:0]       pos;

  function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = !busy && !start;
  assign out_valid        = out_valid_r;
  assign out_found        = found_r;
  assign out_result_index = res_idx_r;
  assign out_bit_value    = bit_val_r;
  assign out_index_error  = err_r;

  // saturate the configured size to the storage size
  assign lim = (CMP_W'(num_bits_r) > CMP_W'(MAX_BITS)) ? CMP_W'(MAX_BITS)
                                                       : CMP_W'(num_bits_r);

  assign cur_word = rd_vld_r ? rd_data_r : '0;
  assign scan_vec = want_r ? cur_word : ~cur_word;
  assign bit_mask = WORD_BITS'(1) << bit_r;
  assign pos      = CMP_W'(pbase_r) + CMP_W'(low_bit(scan_vec));

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    base_nxt      = base_r;
    pbase_nxt     = pbase_r;
    pend_nxt      = pend_r;
    plast_nxt     = plast_r;
    issued_nxt    = issued_r;
    want_nxt      = want_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    bit_nxt       = bit_r;
    num_bits_nxt  = num_bits_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    found_nxt     = found_r;
    res_idx_nxt   = res_idx_r;
    bit_val_nxt   = bit_val_r;
    err_nxt       = err_r;
    mem_we        = 1'b0;
    mem_wdata     = '0;

    if (cfg_valid && cfg_ready) begin
      num_bits_nxt = cfg_num_bits;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt    = in_kind;
          idx_nxt     = in_bit_index;
          word_nxt    = '0;
          base_nxt    = '0;
          pend_nxt    = 1'b0;
          issued_nxt  = 1'b0;
          found_nxt   = 1'b0;
          res_idx_nxt = '0;
          bit_val_nxt = 1'b0;
          err_nxt     = 1'b0;
          case (in_kind)
            KIND_SET_BIT, KIND_CLR_BIT, KIND_READ_BIT: begin
              if (CMP_W'(in_bit_index) >= lim) begin
                err_nxt       = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_LOCATE;
              end
            end
            KIND_SET_ALL: begin
              state_nxt = ST_FILL;
            end
            KIND_CLR_ALL: begin
              valid_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            KIND_FIND_SET, KIND_FIND_CLR: begin
              want_nxt  = (in_kind == KIND_FIND_SET);
              state_nxt = ST_SCAN;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // walk word bases until the one that holds the bit
      ST_LOCATE: begin
        if ((CMP_W'(idx_r) < CMP_W'(base_r) + CMP_W'(WORD_BITS)) ||
            (word_r == LAST_WORD)) begin
          bit_nxt   = BIT_W'(CMP_W'(idx_r) - CMP_W'(base_r));
          state_nxt = ST_MODIFY;
        end else begin
          word_nxt = word_r + WA_W'(1);
          base_nxt = base_r + BASE_W'(WORD_BITS);
        end
      end

      ST_MODIFY: begin
        if (kind_r == KIND_READ_BIT) begin
          bit_val_nxt = cur_word[bit_r];
        end else begin
          mem_we           = 1'b1;
          mem_wdata        = (kind_r == KIND_SET_BIT) ? (cur_word | bit_mask)
                                                      : (cur_word & ~bit_mask);
          valid_nxt[word_r] = 1'b1;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      // read one word per cycle, examine the previous read
      ST_SCAN: begin
        if (!issued_r) begin
          pend_nxt  = 1'b1;
          pbase_nxt = base_r;
          plast_nxt = (word_r == LAST_WORD);
          if (word_r == LAST_WORD) begin
            issued_nxt = 1'b1;
          end else begin
            word_nxt = word_r + WA_W'(1);
            base_nxt = base_r + BASE_W'(WORD_BITS);
          end
        end
        if (pend_r && (scan_vec != '0)) begin
          if (pos < lim) begin
            found_nxt   = 1'b1;
            res_idx_nxt = IDX_W'(pos);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (pend_r && plast_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_FILL: begin
        mem_we            = 1'b1;
        mem_wdata         = '1;
        valid_nxt[word_r] = 1'b1;
        if (word_r == LAST_WORD) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          word_nxt = word_r + WA_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      num_bits_r  <= NUM_BITS_W'(NUM_BITS_RST);
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      issued_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      num_bits_r  <= num_bits_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      issued_r    <= issued_nxt;
    end
    word_r    <= word_nxt;
    base_r    <= base_nxt;
    pbase_r   <= pbase_nxt;
    plast_r   <= plast_nxt;
    want_r    <= want_nxt;
    kind_r    <= kind_nxt;
    idx_r     <= idx_nxt;
    bit_r     <= bit_nxt;
    found_r   <= found_nxt;
    res_idx_r <= res_idx_nxt;
    bit_val_r <= bit_val_nxt;
    err_r     <= err_nxt;
  end

  // bitmap word memory, single port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[word_r] <= mem_wdata;
    end
    rd_data_r <= mem[word_r];
    rd_vld_r  <= valid_r[word_r];
  end

  `ABS_ASSERT_RST(a_reset_idle, !rst_n |=> !busy && !out_valid, "not idle after reset")
  `ABS_ASSERT(a_strobe_when_idle, out_valid |-> !busy, "result strobe while busy")
  `ABS_ASSERT(a_strobe_cause, out_valid |-> $past(busy || start), "result beat without request")
  `ABS_ASSERT(a_err_alone, out_valid && out_index_error |-> !out_found && !out_bit_value, "error beat carries data")
  `ABS_ASSERT(a_clear_all, start && !busy && in_kind == KIND_CLR_ALL |=> valid_r == '0, "clear all left words valid")

endmodule

// ===== verif/tb_allocation_bitmap_scan_unit.sv =====
module tb_allocation_bitmap_scan_unit;
  import abs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd7;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
    logic             bit_value;
    logic             index_error;
  } scan_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [IDX_W-1:0]      in_bit_index = '0;
  logic                  out_valid;
  logic                  out_found;
  logic [IDX_W-1:0]      out_result_index;
  logic                  out_bit_value;
  logic                  out_index_error;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [NUM_BITS_W-1:0] cfg_num_bits = '0;

  // predictor state
  logic [MAX_BITS_DEF-1:0] occupancy = '0;
  logic [NUM_BITS_W-1:0]   model_num_bits = NUM_BITS_W'(NUM_BITS_RST);
  scan_result_t            pending_results[$];

  int mismatches = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int finds_hit = 0;
  int index_errors = 0;
  int num_bits_writes = 0;

  allocation_bitmap_scan_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_bit_index     (in_bit_index),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_result_index (out_result_index),
    .out_bit_value    (out_bit_value),
    .out_index_error  (out_index_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_num_bits     (cfg_num_bits)
  );

  always #10 clk = ~clk;

  function automatic int active_limit();
    return (model_num_bits > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(model_num_bits);
  endfunction

  function automatic logic lowest_match(input logic want, output int pos);
    pos = 0;
    for (int i = 0; i < MAX_BITS_DEF; i++) begin
      if (occupancy[i] == want) begin
        pos = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic scan_result_t predict_scan_result(input logic [KIND_W-1:0] kind,
                                                       input logic [IDX_W-1:0] idx);
    scan_result_t r;
    int limit;
    int pos;
    r = '0;
    limit = active_limit();
    case (kind)
      KIND_SET_BIT, KIND_CLR_BIT, KIND_READ_BIT: begin
        if (int'(idx) >= limit) begin
          r.index_error = 1'b1;
        end else if (kind == KIND_SET_BIT) begin
          occupancy[idx] = 1'b1;
        end else if (kind == KIND_CLR_BIT) begin
          occupancy[idx] = 1'b0;
        end else begin
          r.bit_value = occupancy[idx];
        end
      end
      // bits above num_bits change too but are never reported
      KIND_SET_ALL: occupancy = '1;
      KIND_CLR_ALL: occupancy = '0;
      KIND_FIND_SET, KIND_FIND_CLR: begin
        if (lowest_match(kind == KIND_FIND_SET, pos) && pos < limit) begin
          r.found = 1'b1;
          r.index = IDX_W'(pos);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_scan_result();
    scan_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result beat with no request outstanding");
    end else begin
      want = pending_results.pop_front();
      results_checked++;
      if (out_found !== want.found)
        report_mismatch($sformatf("found got %0b want %0b", out_found, want.found));
      if (out_result_index !== want.index)
        report_mismatch($sformatf("result_index got %0d want %0d", out_result_index,
                                  want.index));
      if (out_bit_value !== want.bit_value)
        report_mismatch($sformatf("bit_value got %0b want %0b", out_bit_value,
                                  want.bit_value));
      if (out_index_error !== want.index_error)
        report_mismatch($sformatf("index_error got %0b want %0b", out_index_error,
                                  want.index_error));
    end
  endtask

  // outputs are stable mid-cycle
  always @(negedge clk) begin
    if (rst_n && out_valid) check_scan_result();
  end

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx);
    scan_result_t r;
    start <= 1'b1;
    in_kind <= kind;
    in_bit_index <= idx;
    do @(negedge clk); while (busy);
    r = predict_scan_result(kind, idx);
    pending_results.push_back(r);
    requests_sent++;
    if (r.found) finds_hit++;
    if (r.index_error) index_errors++;
    @(posedge clk);
  endtask

  task automatic pause_requests(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) pause_requests(0);
    else if (r < 85) pause_requests($urandom_range(1, 3));
    else if (r < 97) pause_requests($urandom_range(4, 12));
    else pause_requests($urandom_range(20, 60));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_num_bits(input logic [NUM_BITS_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_num_bits <= value;
    do @(negedge clk); while (!cfg_ready);
    model_num_bits = value;
    num_bits_writes++;
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_single_bit_ops();
    send_request(KIND_READ_BIT, 10'd0);
    send_request(KIND_SET_BIT, 10'd0);
    send_request(KIND_READ_BIT, 10'd0);
    send_request(KIND_SET_BIT, 10'd1023);
    send_request(KIND_FIND_SET, 10'd0);
    send_request(KIND_CLR_BIT, 10'd0);
    send_request(KIND_FIND_SET, 10'd1023);
    send_request(KIND_FIND_CLR, 10'd0);
  endtask

  task automatic test_bulk_ops();
    send_request(KIND_SET_ALL, 10'd0);
    send_request(KIND_FIND_CLR, 10'd0);
    send_request(KIND_CLR_BIT, 10'd31);
    send_request(KIND_FIND_CLR, 10'd0);
    send_request(KIND_CLR_ALL, 10'd0);
    send_request(KIND_FIND_SET, 10'd0);
  endtask

  task automatic test_limit_edges();
    // only bits above the limit stay set, so find set must miss
    write_num_bits(11'd1);
    send_request(KIND_SET_ALL, 10'd0);
    send_request(KIND_CLR_BIT, 10'd0);
    send_request(KIND_FIND_SET, 10'd0);
    send_request(KIND_SET_BIT, 10'd1);
    write_num_bits(11'd0);
    send_request(KIND_READ_BIT, 10'd0);
    send_request(KIND_FIND_CLR, 10'd0);
    send_request(KIND_UNKNOWN, 10'd1023);
    // saturates to the full bitmap
    write_num_bits(11'd2047);
    send_request(KIND_READ_BIT, 10'd1023);
    send_request(KIND_FIND_SET, 10'd0);
  endtask

  task automatic test_random_traffic();
    logic [NUM_BITS_W-1:0] settings[8];
    logic [KIND_W-1:0]     kind;
    logic [IDX_W-1:0]      idx;
    int                    r;
    int                    limit;
    int                    pos;
    settings = '{11'd1024, 11'd32, NUM_BITS_W'($urandom_range(1, 64)), 11'd1024,
                 11'd2047, NUM_BITS_W'($urandom_range(1, 1024)), 11'd1, 11'd1025};
    for (int p = 0; p < 8; p++) begin
      write_num_bits(settings[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 32) kind = KIND_SET_BIT;
        else if (r < 50) kind = KIND_CLR_BIT;
        else if (r < 64) kind = KIND_FIND_SET;
        else if (r < 78) kind = KIND_FIND_CLR;
        else if (r < 92) kind = KIND_READ_BIT;
        else if (r < 95) kind = KIND_SET_ALL;
        else if (r < 98) kind = KIND_CLR_ALL;
        else kind = KIND_UNKNOWN;
        limit = active_limit();
        r = $urandom_range(0, 99);
        if (limit == 0 || r < 10) begin
          idx = IDX_W'($urandom_range(0, 1023));
        end else if (r < 40 && kind == KIND_SET_BIT && lowest_match(1'b0, pos)
                     && pos < limit) begin
          // allocate the lowest free bit
          idx = IDX_W'(pos);
        end else if (r < 50) begin
          if (limit >= MAX_BITS_DEF) idx = IDX_W'(MAX_BITS_DEF - 1);
          else idx = IDX_W'(limit - $urandom_range(0, 1));
        end else begin
          idx = IDX_W'($urandom_range(0, limit - 1));
        end
        send_request(kind, idx);
        random_gap();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_bit_ops();
    test_bulk_ops();
    test_limit_edges();
    test_random_traffic();
    drain_results();
    $display("%0d requests, %0d results checked: %0d finds located a bit, %0d index errors",
             requests_sent, results_checked, finds_hit, index_errors);
    $display("num_bits rewritten %0d times, covering 0, 1, 32 and values past the bitmap size",
             num_bits_writes);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/abs_pkg.sv
rtl/allocation_bitmap_scan_unit.sv
verif/tb_allocation_bitmap_scan_unit.sv
